FILE: rtl/ssd_pkg.sv
// Shared types and constants for the SSD stereo disparity core.
// No dependencies; imported by every module of the block.
package ssd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 3;
   localparam int DISP_LIMIT = 63;
   localparam int PIXEL_BITS = 8;

   localparam int WIN   = 2 * MAX_RADIUS + 1;
   localparam int LINES = 2 * MAX_RADIUS;
   localparam int RWIN  = WIN + DISP_LIMIT;

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int CNT_BITS  = ADDR_BITS + 1;
   localparam int WIN_BITS  = $clog2(WIN);
   localparam int LINE_BITS = $clog2(LINES);
   localparam int RAD_BITS  = 2;
   localparam int DISP_BITS = 6;
   localparam int TERM_BITS = 2 * PIXEL_BITS;
   // 49 terms of at most 255^2 fit in 22 bits
   localparam int SUM_BITS  = TERM_BITS + $clog2(WIN * WIN);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef pixel_type [WIN-1:0] column_type;

   typedef struct packed {
      logic shift;
      logic step;
   } cell_ctl_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] s;
      logic [SUM_BITS-1:0] e;
      logic [SUM_BITS-1:0] best_s;
      logic [SUM_BITS-1:0] best_e;
   } cmp_operands_type;

   typedef struct packed {
      logic done;
      logic less;
   } cmp_result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_DRAIN,
      ST_DECIDE,
      ST_CMP,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      CMP_IDLE,
      CMP_SQ_S,
      CMP_SQ_B,
      CMP_P_LO,
      CMP_P_HI,
      CMP_Q_LO,
      CMP_Q_HI,
      CMP_SUM,
      CMP_DONE
   } cmp_state_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_WINDOW_RADIUS,
      CSR_MAX_DISPARITY,
      CSR_NORMALIZED_MODE
   } csr_index_type;

endpackage

FILE: rtl/stereo_ssd_disparity_core.sv
// SSD stereo disparity core. Per pixel: accept, line-store write, then a column-serial
// sum over the right cell chain for each candidate shift, plus the normalised
// cross-multiply compare per candidate when it runs, and posting the word; pixels
// without a search skip the sum.
// Synchronous reset; afterwards a clearing pass over every line-store address holds
// req_stall high. Configuration writes are accepted at any time.
module stereo_ssd_disparity_core import ssd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_BITS-1:0] req_left_pixel,
   input  logic [PIXEL_BITS-1:0] req_right_pixel,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DISP_BITS-1:0]  rsp_disparity,
   output logic [ADDR_BITS-1:0]  rsp_center_column,
   output logic [ADDR_BITS-1:0]  rsp_center_row,
   output logic                  rsp_frame_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [CNT_BITS-1:0]   csr_data
);

   // row mod 6 via reciprocal 170/1024 (underestimates by at most one)
   function automatic logic [LINE_BITS-1:0] mod_lines(input logic [ADDR_BITS-1:0] v);
      logic [17:0] prod;
      logic [7:0]  q;
      logic [10:0] rem;
      prod = {8'd0, v} * 18'd170;
      q    = prod[17:10];
      rem  = {1'b0, v} - ({3'd0, q} * 11'd6);
      if (rem >= 11'(LINES)) begin
         rem = rem - 11'(LINES);
      end
      return rem[LINE_BITS-1:0];
   endfunction

   function automatic logic [LINE_BITS-1:0] line_of(input logic [LINE_BITS-1:0] rm,
                                                    input logic [2:0] r2,
                                                    input logic [2:0] k);
      logic [4:0] s;
      s = {2'd0, rm} + 5'(LINES) - {2'd0, r2} + {2'd0, k};
      if (s >= 5'(2 * LINES)) begin
         s = s - 5'(2 * LINES);
      end else if (s >= 5'(LINES)) begin
         s = s - 5'(LINES);
      end
      return s[LINE_BITS-1:0];
   endfunction

   // configuration
   logic [CNT_BITS-1:0]  width_ff, height_ff;
   logic [RAD_BITS-1:0]  radius_ff;
   logic [DISP_BITS-1:0] maxd_ff;
   logic                 norm_ff;
   logic [CNT_BITS-1:0]  w_eff, h_eff;
   logic [2:0]           r2;
   logic [ADDR_BITS-1:0] r_ext, r2_ext;

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [CNT_BITS-1:0]  col_cnt_ff, row_cnt_ff;

   // current item
   logic [ADDR_BITS-1:0] row_ff, col_ff, crow_ff, ccol_ff;
   logic [LINE_BITS-1:0] rmod_ff;
   pixel_type            lpix_ff, rpix_ff;
   logic                 last_ff;

   // search
   logic [DISP_BITS-1:0] d_ff, dmax_ff, best_d_ff;
   logic [WIN_BITS-1:0]  a_ff;
   logic [SUM_BITS-1:0]  acc_s_ff, acc_e_ff, best_s_ff, best_e_ff;
   logic                 take_ff, term_vld_ff;
   logic [TERM_BITS-1:0] sqd_ff [WIN];
   logic [TERM_BITS-1:0] sqr_ff [WIN];
   logic [TERM_BITS-1:0] sqd_in [WIN];
   logic [TERM_BITS-1:0] sqr_in [WIN];
   logic [SUM_BITS-1:0]  col_s, col_e;

   // output register
   logic                 rsp_valid_ff;
   logic [DISP_BITS-1:0] rsp_disparity_ff;
   logic [ADDR_BITS-1:0] rsp_col_ff, rsp_row_ff;
   logic                 rsp_last_ff;

   // accept path
   logic                 accept, wrap, skip;
   logic [CNT_BITS-1:0]  cc_a, rc_a, cc_b, rc_b;

   // windows and line stores
   column_type           lwin_ff [WIN];
   column_type           right_win [RWIN];
   column_type           right_scan [RWIN];
   column_type           scan_head [WIN];
   column_type           new_lcol, new_rcol;
   logic [2*PIXEL_BITS-1:0] mem_rd [LINES];
   logic                 clearing;

   // control
   cell_ctl_type         cell_ctl;
   logic                 cmp_start, load_out, decide_take, last_d;
   logic                 early, inner;
   logic [ADDR_BITS-1:0] avail;
   cmp_operands_type     cmp_ops;
   cmp_result_type       cmp_res;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CNT_BITS'(1);
      end else if (width_ff > CNT_BITS'(MAX_WIDTH)) begin
         w_eff = CNT_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = CNT_BITS'(1);
      end else if (height_ff > CNT_BITS'(MAX_HEIGHT)) begin
         h_eff = CNT_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign r2     = {radius_ff, 1'b0};
   assign r_ext  = ADDR_BITS'(radius_ff);
   assign r2_ext = ADDR_BITS'(r2);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CNT_BITS'(640);
         height_ff <= CNT_BITS'(480);
         radius_ff <= RAD_BITS'(1);
         maxd_ff   <= DISP_BITS'(16);
         norm_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:    height_ff <= csr_data;
            CSR_WINDOW_RADIUS:   radius_ff <= csr_data[RAD_BITS-1:0];
            CSR_MAX_DISPARITY:   maxd_ff   <= csr_data[DISP_BITS-1:0];
            CSR_NORMALIZED_MODE: norm_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position of the incoming word
   assign accept = req_valid && (state_ff == ST_IDLE);
   assign cc_a   = req_frame_start ? '0 : col_cnt_ff;
   assign rc_a   = req_frame_start ? '0 : row_cnt_ff;
   assign wrap   = (cc_a >= w_eff);
   assign cc_b   = wrap ? '0 : cc_a;
   assign rc_b   = wrap ? rc_a + CNT_BITS'(1) : rc_a;
   assign skip   = (rc_b >= h_eff);

   assign clearing = (state_ff == ST_CLEAR);

   // line stores
   for (genvar i = 0; i < LINES; i++) begin : g_line
      logic                    wr_en;
      logic [ADDR_BITS-1:0]    wr_addr;
      logic [2*PIXEL_BITS-1:0] wr_data;
      assign wr_en   = clearing ||
                       ((state_ff == ST_LOAD) && (rmod_ff == LINE_BITS'(i)));
      assign wr_addr = clearing ? clr_addr_ff : col_ff;
      assign wr_data = clearing ? '0 : {lpix_ff, rpix_ff};
      ssd_line_mem u_line (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (accept && !skip),
         .rd_addr (cc_b[ADDR_BITS-1:0]),
         .rd_data (mem_rd[i])
      );
   end

   // new window column: older rows from the stores, newest row from the port
   always_comb begin
      logic [LINE_BITS-1:0] ln;
      for (int k = 0; k < WIN; k++) begin
         ln = line_of(rmod_ff, r2, 3'(k));
         if (3'(k) < r2) begin
            new_lcol[k] = mem_rd[ln][2*PIXEL_BITS-1:PIXEL_BITS];
            new_rcol[k] = mem_rd[ln][PIXEL_BITS-1:0];
         end else if (3'(k) == r2) begin
            new_lcol[k] = lpix_ff;
            new_rcol[k] = rpix_ff;
         end else begin
            new_lcol[k] = '0;
            new_rcol[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            lwin_ff[i] <= '0;
         end
      end else if (cell_ctl.shift) begin
         lwin_ff[0] <= new_lcol;
         for (int i = 1; i < WIN; i++) begin
            lwin_ff[i] <= lwin_ff[i-1];
         end
      end
   end

   // right window chain
   for (genvar i = 0; i < RWIN; i++) begin : g_cell
      column_type cell_in, scan_nb;
      if (i == 0) begin : g_head
         assign cell_in = new_rcol;
      end else begin : g_body
         assign cell_in = right_win[i-1];
      end
      if (i == RWIN - 1) begin : g_tail
         assign scan_nb = '0;
      end else begin : g_inner
         assign scan_nb = right_scan[i+1];
      end
      ssd_col_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .col_in   (cell_in),
         .scan_in  (scan_nb),
         .col_out  (right_win[i]),
         .scan_out (right_scan[i])
      );
   end

   for (genvar i = 0; i < WIN; i++) begin : g_head_tap
      assign scan_head[i] = right_scan[i];
   end

   // column terms for window column a against scan column a
   always_comb begin
      column_type lc, rc;
      pixel_type  df;
      lc = lwin_ff[a_ff];
      rc = scan_head[a_ff];
      for (int k = 0; k < WIN; k++) begin
         df = (lc[k] >= rc[k]) ? lc[k] - rc[k] : rc[k] - lc[k];
         if (3'(k) <= r2) begin
            sqd_in[k] = TERM_BITS'(df) * TERM_BITS'(df);
            sqr_in[k] = TERM_BITS'(rc[k]) * TERM_BITS'(rc[k]);
         end else begin
            sqd_in[k] = '0;
            sqr_in[k] = '0;
         end
      end
   end

   always_comb begin
      col_s = '0;
      col_e = '0;
      for (int k = 0; k < WIN; k++) begin
         col_s = col_s + SUM_BITS'(sqd_ff[k]);
         col_e = col_e + SUM_BITS'(sqr_ff[k]);
      end
   end

   assign early  = (row_ff < r_ext) || (col_ff < r_ext);
   assign inner  = (row_ff >= r2_ext) && (col_ff >= r2_ext);
   assign avail  = col_ff - r2_ext;
   assign last_d = (d_ff == dmax_ff);

   assign cmp_ops.s      = acc_s_ff;
   assign cmp_ops.e      = acc_e_ff;
   assign cmp_ops.best_s = best_s_ff;
   assign cmp_ops.best_e = best_e_ff;

   ssd_cmp_unit u_cmp (
      .clock (clock),
      .reset (reset),
      .start (cmp_start),
      .ops   (cmp_ops),
      .res   (cmp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cell_ctl.shift = 1'b0;
      cell_ctl.step  = 1'b0;
      cmp_start      = 1'b0;
      load_out       = 1'b0;
      decide_take    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_BITS'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && !skip) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cell_ctl.shift = 1'b1;
            if (early) begin
               state_in = ST_IDLE;
            end else if (inner) begin
               state_in = ST_SUM;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SUM: begin
            if ({1'b0, a_ff} == {1'b0, r2}) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = ST_NEXT;
            if (d_ff == '0) begin
               decide_take = 1'b1;
            end else if (!norm_ff) begin
               decide_take = (acc_s_ff < best_s_ff);
            end else if (acc_e_ff == '0) begin
               decide_take = 1'b0;
            end else if (best_e_ff == '0) begin
               decide_take = 1'b1;
            end else begin
               cmp_start = 1'b1;
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            if (cmp_res.done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (last_d) begin
               state_in = ST_OUT;
            end else begin
               cell_ctl.step = 1'b1;
               state_in      = ST_SUM;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         term_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end
         if (accept) begin
            if (skip) begin
               col_cnt_ff <= cc_b;
               row_cnt_ff <= h_eff;
            end else begin
               col_cnt_ff <= cc_b + CNT_BITS'(1);
               row_cnt_ff <= rc_b;
            end
         end
         term_vld_ff <= (state_ff == ST_SUM);
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && !skip) begin
         row_ff  <= rc_b[ADDR_BITS-1:0];
         col_ff  <= cc_b[ADDR_BITS-1:0];
         rmod_ff <= mod_lines(rc_b[ADDR_BITS-1:0]);
         lpix_ff <= req_left_pixel;
         rpix_ff <= req_right_pixel;
         last_ff <= (rc_b == h_eff - CNT_BITS'(1)) && (cc_b == w_eff - CNT_BITS'(1));
      end
      if (state_ff == ST_LOAD) begin
         crow_ff   <= row_ff - r_ext;
         ccol_ff   <= col_ff - r_ext;
         best_d_ff <= '0;
         d_ff      <= '0;
         a_ff      <= '0;
         dmax_ff   <= (ADDR_BITS'(maxd_ff) < avail) ? maxd_ff : avail[DISP_BITS-1:0];
      end
      if (state_ff == ST_SUM) begin
         a_ff <= a_ff + WIN_BITS'(1);
      end
      for (int k = 0; k < WIN; k++) begin
         sqd_ff[k] <= sqd_in[k];
         sqr_ff[k] <= sqr_in[k];
      end
      if (state_ff == ST_LOAD || state_ff == ST_NEXT) begin
         acc_s_ff <= '0;
         acc_e_ff <= '0;
      end else if (term_vld_ff) begin
         acc_s_ff <= acc_s_ff + col_s;
         acc_e_ff <= acc_e_ff + col_e;
      end
      if (state_ff == ST_DECIDE) begin
         take_ff <= decide_take;
      end else if (state_ff == ST_CMP && cmp_res.done) begin
         take_ff <= cmp_res.less;
      end
      if (state_ff == ST_NEXT) begin
         if (take_ff) begin
            best_s_ff <= acc_s_ff;
            best_e_ff <= acc_e_ff;
            best_d_ff <= d_ff;
         end
         if (!last_d) begin
            d_ff <= d_ff + DISP_BITS'(1);
            a_ff <= '0;
         end
      end
      if (load_out) begin
         rsp_disparity_ff <= best_d_ff;
         rsp_col_ff       <= ccol_ff;
         rsp_row_ff       <= crow_ff;
         rsp_last_ff      <= last_ff;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_disparity     = rsp_disparity_ff;
   assign rsp_center_column = rsp_col_ff;
   assign rsp_center_row    = rsp_row_ff;
   assign rsp_frame_last    = rsp_last_ff;

`ifndef SYNTHESIS
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result word during line-store clear");
   a_disp_range: assert property (@(posedge clock) disable iff (reset)
      load_out |-> best_d_ff <= maxd_ff)
      else $error("disparity beyond configured search range");
   a_col_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ({1'b0, a_ff} <= {1'b0, r2}))
      else $error("window column index past window");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT) |-> d_ff <= dmax_ff)
      else $error("candidate shift past limit");
`endif

endmodule

FILE: rtl/ssd_line_mem.sv
// One line of the left and right line stores, 1024 x 16 bit.
// Depends on ssd_pkg for widths.
module ssd_line_mem import ssd_pkg::*; (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_BITS-1:0]    wr_addr,
   input  logic [2*PIXEL_BITS-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_BITS-1:0]    rd_addr,
   output logic [2*PIXEL_BITS-1:0] rd_data
);

   logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ssd_col_cell.sv
// One column cell of the right window chain: window column plus scan copy.
// Depends on ssd_pkg for column and control types.
module ssd_col_cell import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  column_type   col_in,
   input  column_type   scan_in,
   output column_type   col_out,
   output column_type   scan_out
);

   column_type win_ff;
   column_type scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctl.shift) begin
         win_ff <= col_in;
      end
   end

   // scan copy takes the shifted window, then walks towards cell 0
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         scan_ff <= col_in;
      end else if (ctl.step) begin
         scan_ff <= scan_in;
      end
   end

   assign col_out  = win_ff;
   assign scan_out = scan_ff;

endmodule

FILE: rtl/ssd_cmp_unit.sv
// Exact compare s^2 * best_e < best_s^2 * e using one shared 22x22 multiplier.
// Depends on ssd_pkg for operand and result structs.
module ssd_cmp_unit import ssd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cmp_operands_type ops,
   output cmp_result_type   res
);

   cmp_state_type state_ff, state_in;
   logic [SUM_BITS-1:0]   mul_a, mul_b;
   logic [2*SUM_BITS-1:0] prod;
   logic [2*SUM_BITS-1:0] sqs_ff, sqb_ff, pl_ff, ph_ff, ql_ff, qh_ff;
   logic [3*SUM_BITS-1:0] p_ff, q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CMP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         CMP_IDLE: begin
            if (start) begin
               state_in = CMP_SQ_S;
            end
         end
         CMP_SQ_S: begin
            mul_a    = ops.s;
            mul_b    = ops.s;
            state_in = CMP_SQ_B;
         end
         CMP_SQ_B: begin
            mul_a    = ops.best_s;
            mul_b    = ops.best_s;
            state_in = CMP_P_LO;
         end
         CMP_P_LO: begin
            mul_a    = sqs_ff[SUM_BITS-1:0];
            mul_b    = ops.best_e;
            state_in = CMP_P_HI;
         end
         CMP_P_HI: begin
            mul_a    = sqs_ff[2*SUM_BITS-1:SUM_BITS];
            mul_b    = ops.best_e;
            state_in = CMP_Q_LO;
         end
         CMP_Q_LO: begin
            mul_a    = sqb_ff[SUM_BITS-1:0];
            mul_b    = ops.e;
            state_in = CMP_Q_HI;
         end
         CMP_Q_HI: begin
            mul_a    = sqb_ff[2*SUM_BITS-1:SUM_BITS];
            mul_b    = ops.e;
            state_in = CMP_SUM;
         end
         CMP_SUM:  state_in = CMP_DONE;
         CMP_DONE: state_in = CMP_IDLE;
         default:  state_in = CMP_IDLE;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      case (state_ff)
         CMP_SQ_S: sqs_ff <= prod;
         CMP_SQ_B: sqb_ff <= prod;
         CMP_P_LO: pl_ff  <= prod;
         CMP_P_HI: ph_ff  <= prod;
         CMP_Q_LO: ql_ff  <= prod;
         CMP_Q_HI: qh_ff  <= prod;
         CMP_SUM: begin
            p_ff <= {ph_ff, {SUM_BITS{1'b0}}} + {{SUM_BITS{1'b0}}, pl_ff};
            q_ff <= {qh_ff, {SUM_BITS{1'b0}}} + {{SUM_BITS{1'b0}}, ql_ff};
         end
         default: ;
      endcase
   end

   assign res.done = (state_ff == CMP_DONE);
   assign res.less = (p_ff < q_ff);

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == CMP_IDLE)
      else $error("compare started while busy");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == CMP_IDLE) |-> ##8 res.done)
      else $error("compare result not ready after eight cycles");
   a_done_back: assert property (@(posedge clock) disable iff (reset)
      res.done |=> state_ff == CMP_IDLE)
      else $error("compare unit did not return to idle");
`endif

endmodule
